// ===== src/histogram_pair_distance_accumulator_macros.svh =====
// Assertion macros used by the histogram pair distance accumulator datapath.
`ifndef HISTOGRAM_PAIR_DISTANCE_ACCUMULATOR_MACROS_SVH
`define HISTOGRAM_PAIR_DISTANCE_ACCUMULATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Property holds at every edge out of reset.
`define HPDA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Consequent holds in the cycle after the antecedent.
`define HPDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HPDA_ASSERT(lbl, clk, rst_n, prop, msg)
`define HPDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/hpda_pkg.sv =====
// Shared types and constants of the histogram pair distance accumulator.
`default_nettype none

package hpda_pkg;

  // Field widths
  localparam int unsigned CNT_IN_W   = 16;
  localparam int unsigned ABS_W      = 32;
  localparam int unsigned SQ_W       = 48;
  localparam int unsigned CUBE_W     = 64;
  localparam int unsigned MAX_W      = 16;
  localparam int unsigned MISM_W     = 17;
  localparam int unsigned GAP_W      = 48;
  localparam int unsigned BINS_W     = 17;
  localparam int unsigned RGAP_W     = 34;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 248;

  // Running cumulative difference clamps at +/- (2^33 - 1)
  localparam logic signed [RGAP_W-1:0] GAP_LIM = 34'sh1_FFFF_FFFF;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic [5:0]          pad;
    logic [BINS_W-1:0]   bins_seen;
    logic [GAP_W-1:0]    prefix_gap_sum;
    logic [MISM_W-1:0]   mismatch_bins;
    logic [MAX_W-1:0]    max_abs_diff;
    logic [CUBE_W-1:0]   cube_diff_sum;
    logic [SQ_W-1:0]     sq_diff_sum;
    logic [ABS_W-1:0]    abs_diff_sum;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch input item, form difference
    logic phase1;   // square, abs/max/mismatch, running gap
    logic phase2;   // cube, square sum, gap sum, bin count
    logic phase3;   // cube sum
    logic emit;     // load result register, clear accumulators
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic close;     // this item ends the histogram pair, or the bin count is at MAX_BINS
    logic out_busy;  // result register full and not taken this cycle
  } status_t;

endpackage

`default_nettype wire

// ===== src/hpda_ctrl.sv =====
// Sequencing state machine of the histogram pair distance accumulator.
`default_nettype none

module hpda_ctrl
  import hpda_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQR  = 3'd1;
  localparam logic [2:0] S_CUBE = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q, state_d;

  assign s_axis_tready = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.capture = 1'b1;
          state_d       = S_SQR;
        end
      end
      S_SQR: begin
        cmd_o.phase1 = 1'b1;
        state_d      = S_CUBE;
      end
      S_CUBE: begin
        cmd_o.phase2 = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.phase3 = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        // hold here while a closing result waits for the output slot
        if (!status_i.close) begin
          state_d = S_IDLE;
        end else if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/hpda_datapath.sv =====
// Difference, multiply and saturating accumulate datapath with result register.
`default_nettype none

`include "histogram_pair_distance_accumulator_macros.svh"

module hpda_datapath
  import hpda_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned MAX_BINS   = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(MAX_BINS + 1);
  localparam int unsigned BCMP_W = (CNT_W > BINS_W) ? CNT_W : BINS_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BINS);
  localparam logic [CNT_IN_W-1:0] CNT_MASK = (COUNT_BITS >= CNT_IN_W) ?
      {CNT_IN_W{1'b1}} : CNT_IN_W'((64'd1 << COUNT_BITS) - 64'd1);

  // Per-item working registers
  logic [CNT_IN_W-1:0]      d_q;
  logic signed [CNT_IN_W:0] diff_q;
  logic                     last_q;
  logic [2*CNT_IN_W-1:0]    sq_q;
  logic [3*CNT_IN_W-1:0]    cube_q;

  // Accumulators
  logic [ABS_W-1:0]         abs_acc_q;
  logic [SQ_W-1:0]          sq_acc_q;
  logic [CUBE_W-1:0]        cube_acc_q;
  logic [MAX_W-1:0]         max_acc_q;
  logic [MISM_W-1:0]        mism_acc_q;
  logic signed [RGAP_W-1:0] rg_q;
  logic [GAP_W-1:0]         gap_acc_q;
  logic [CNT_W-1:0]         bin_cnt_q;

  // Result slot
  result_t result_q;
  logic    out_valid_q;

  logic [CNT_IN_W-1:0]      cnt_a, cnt_b, d_in;
  logic [ABS_W:0]           abs_sum;
  logic [SQ_W:0]            sq_sum;
  logic [CUBE_W:0]          cube_sum;
  logic [GAP_W:0]           gap_sum;
  logic [MISM_W-1:0]        mism_d;
  logic signed [RGAP_W:0]   rg_sum;
  logic signed [RGAP_W-1:0] rg_d, rg_neg;
  logic [RGAP_W-2:0]        rg_mag;
  logic [BCMP_W-1:0]        cnt_ext;
  logic [BINS_W-1:0]        bins_out;

  // Masked counts and absolute difference
  assign cnt_a = s_axis_tdata[CNT_IN_W-1:0] & CNT_MASK;
  assign cnt_b = s_axis_tdata[2*CNT_IN_W-1:CNT_IN_W] & CNT_MASK;
  assign d_in  = (cnt_a > cnt_b) ? (cnt_a - cnt_b) : (cnt_b - cnt_a);

  // Saturating sums
  assign abs_sum  = {1'b0, abs_acc_q} + (ABS_W + 1)'(d_q);
  assign sq_sum   = {1'b0, sq_acc_q} + (SQ_W + 1)'(sq_q);
  assign cube_sum = {1'b0, cube_acc_q} + (CUBE_W + 1)'(cube_q);
  assign gap_sum  = {1'b0, gap_acc_q} + (GAP_W + 1)'(rg_mag);
  assign mism_d   = ((d_q != '0) && (mism_acc_q != {MISM_W{1'b1}})) ?
                    (mism_acc_q + MISM_W'(1)) : mism_acc_q;

  // Running cumulative difference, clamped
  assign rg_sum = (RGAP_W + 1)'(rg_q) + (RGAP_W + 1)'(diff_q);
  always_comb begin
    if (rg_sum > (RGAP_W + 1)'(GAP_LIM)) begin
      rg_d = GAP_LIM;
    end else if (rg_sum < -((RGAP_W + 1)'(GAP_LIM))) begin
      rg_d = -GAP_LIM;
    end else begin
      rg_d = rg_sum[RGAP_W-1:0];
    end
  end
  assign rg_neg = -rg_q;
  assign rg_mag = rg_q[RGAP_W-1] ? rg_neg[RGAP_W-2:0] : rg_q[RGAP_W-2:0];

  // Bin count reported with saturation at the field range
  assign cnt_ext  = BCMP_W'(bin_cnt_q);
  assign bins_out = (cnt_ext > BCMP_W'({BINS_W{1'b1}})) ?
                    {BINS_W{1'b1}} : cnt_ext[BINS_W-1:0];

  assign status_o.close    = last_q || (bin_cnt_q == CNT_MAX);
  assign status_o.out_busy = out_valid_q && !m_axis_tready;

  // Per-item payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      d_q    <= d_in;
      diff_q <= $signed({1'b0, cnt_a}) - $signed({1'b0, cnt_b});
      last_q <= s_axis_tlast;
    end
    if (cmd_i.phase1) begin
      sq_q <= d_q * d_q;
    end
    if (cmd_i.phase2) begin
      cube_q <= sq_q * d_q;
    end
  end

  // Accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_acc_q  <= '0;
      sq_acc_q   <= '0;
      cube_acc_q <= '0;
      max_acc_q  <= '0;
      mism_acc_q <= '0;
      rg_q       <= '0;
      gap_acc_q  <= '0;
      bin_cnt_q  <= '0;
    end else if (cmd_i.emit) begin
      abs_acc_q  <= '0;
      sq_acc_q   <= '0;
      cube_acc_q <= '0;
      max_acc_q  <= '0;
      mism_acc_q <= '0;
      rg_q       <= '0;
      gap_acc_q  <= '0;
      bin_cnt_q  <= '0;
    end else begin
      if (cmd_i.phase1) begin
        abs_acc_q  <= abs_sum[ABS_W] ? {ABS_W{1'b1}} : abs_sum[ABS_W-1:0];
        mism_acc_q <= mism_d;
        rg_q       <= rg_d;
        if (d_q > max_acc_q) begin
          max_acc_q <= d_q;
        end
      end
      if (cmd_i.phase2) begin
        sq_acc_q  <= sq_sum[SQ_W] ? {SQ_W{1'b1}} : sq_sum[SQ_W-1:0];
        gap_acc_q <= gap_sum[GAP_W] ? {GAP_W{1'b1}} : gap_sum[GAP_W-1:0];
        if (bin_cnt_q < CNT_MAX) begin
          bin_cnt_q <= bin_cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.phase3) begin
        cube_acc_q <= cube_sum[CUBE_W] ? {CUBE_W{1'b1}} : cube_sum[CUBE_W-1:0];
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_q.pad            <= '0;
      result_q.bins_seen      <= bins_out;
      result_q.prefix_gap_sum <= gap_acc_q;
      result_q.mismatch_bins  <= mism_acc_q;
      result_q.max_abs_diff   <= max_acc_q;
      result_q.cube_diff_sum  <= cube_acc_q;
      result_q.sq_diff_sum    <= sq_acc_q;
      result_q.abs_diff_sum   <= abs_acc_q;
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = result_q;

  `HPDA_ASSERT(a_emit_slot_free, clk_i, rst_ni,
               !cmd_i.emit || !(out_valid_q && !m_axis_tready),
               "result loaded over an untaken result")
  `HPDA_ASSERT_NEXT(a_emit_clears, clk_i, rst_ni, cmd_i.emit,
                    (abs_acc_q == '0) && (bin_cnt_q == '0) && m_axis_tvalid,
                    "accumulators not cleared after result")
  `HPDA_ASSERT(a_gap_clamped, clk_i, rst_ni,
               (rg_q <= GAP_LIM) && (rg_q >= -GAP_LIM),
               "running gap outside its clamp")
  `HPDA_ASSERT(a_max_below_sum, clk_i, rst_ni,
               ABS_W'(max_acc_q) <= abs_acc_q,
               "largest difference exceeds difference sum")

endmodule

`default_nettype wire

// ===== src/histogram_pair_distance_accumulator.sv =====
// Top level of the histogram pair distance accumulator.
//
//   channel   dir  payload (low bit up)                                   done when
//   s_axis    in   tdata: count_a[15:0], count_b[31:16]; tlast: last_bin  tvalid & tready
//   m_axis    out  tdata: abs_diff_sum, sq_diff_sum, cube_diff_sum,       tvalid & tready
//                  max_abs_diff, mismatch_bins, prefix_gap_sum, bins_seen
//
// Each item passes five steps: capture, square, cube, cube sum, close check.
// The 16x16 square and the following 32x16 cube multiply, each registered,
// set the step count. Reset clears all sums, the sequencer and the result valid.
// A closing item holds in the close check while an earlier result waits on
// m_axis_tready; s_axis_tready is high only between items.
`default_nettype none

module histogram_pair_distance_accumulator
  import hpda_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned MAX_BINS   = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // count_a[15:0], count_b[31:16]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // abs_diff_sum[31:0], sq_diff_sum[79:32], cube_diff_sum[143:80],
  // max_abs_diff[159:144], mismatch_bins[176:160], prefix_gap_sum[224:177],
  // bins_seen[241:225], zero fill [247:242]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cmd_t    cmd;
  status_t status;

  hpda_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  hpda_datapath #(
    .COUNT_BITS (COUNT_BITS),
    .MAX_BINS   (MAX_BINS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire
